// ----- design/u8cfv_pkg.sv -----
// ----------------------------------------------------------------------------
// u8cfv_pkg
// Shared types and constants for the control-free UTF-8 string validator.
// ----------------------------------------------------------------------------
package u8cfv_pkg;

   localparam int COUNT_WIDTH    = 16;
   localparam int LEN_WIDTH      = 16;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int MAX_BYTES_WIDTH = 16;

   localparam logic [MAX_BYTES_WIDTH-1:0] MAX_BYTES_RESET = 16'd64;

   // register index, taken from paddr[2]
   localparam logic REG_MAX_NAME_BYTES = 1'b0;

   typedef enum logic [2:0] {
      RULE_NONE = 3'd0,
      RULE_C2   = 3'd1,
      RULE_E0   = 3'd2,
      RULE_ED   = 3'd3,
      RULE_F0   = 3'd4,
      RULE_F4   = 3'd5
   } rule_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       is_last;
   } item_type;

   typedef struct packed {
      logic                 valid_res;
      logic [LEN_WIDTH-1:0] length;
   } result_type;

endpackage

// ----- design/u8cfv_if.sv -----
// ----------------------------------------------------------------------------
// u8cfv channel interfaces
// Valid/ready channels for byte transactions and string results.
// ----------------------------------------------------------------------------
interface u8cfv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       is_last;

   modport source (output valid, output byte_value, output is_last, input ready);
   modport sink   (input valid, input byte_value, input is_last, output ready);
endinterface

interface u8cfv_rsp_if;
   logic        valid;
   logic        ready;
   logic        valid_res;
   logic [15:0] length;

   modport source (output valid, output valid_res, output length, input ready);
   modport sink   (input valid, input valid_res, input length, output ready);
endinterface

// ----- design/u8cfv_csr.sv -----
// ----------------------------------------------------------------------------
// u8cfv_csr
// APB register block holding the maximum string length.
// ----------------------------------------------------------------------------
module u8cfv_csr
   import u8cfv_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                       csr_pready,
   output logic [MAX_BYTES_WIDTH-1:0] max_name_bytes
);

   logic [MAX_BYTES_WIDTH-1:0] max_bytes_ff;
   logic [MAX_BYTES_WIDTH-1:0] max_bytes_in;
   logic                       wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready
                  && (csr_paddr[2] == REG_MAX_NAME_BYTES);

   assign max_bytes_in = wr_en ? csr_pwdata[MAX_BYTES_WIDTH-1:0] : max_bytes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= MAX_BYTES_RESET;
      end else begin
         max_bytes_ff <= max_bytes_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_MAX_NAME_BYTES) begin
         csr_prdata = CSR_DATA_WIDTH'(max_bytes_ff);
      end
   end

   assign max_name_bytes = max_bytes_ff;

endmodule

// ----- design/u8cfv_decode.sv -----
// ----------------------------------------------------------------------------
// u8cfv_decode
// Per-byte UTF-8 sequence tracker with sticky error and saturating count.
// ----------------------------------------------------------------------------
module u8cfv_decode
   import u8cfv_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step_en,
   input  item_type                   item,
   input  logic [MAX_BYTES_WIDTH-1:0] max_name_bytes,
   output result_type                 result
);

   logic [1:0]             due_ff,   due_in;
   rule_type               rule_ff,  rule_in;
   logic                   err_ff,   err_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   logic [1:0]             due_nxt;
   rule_type               rule_nxt;
   logic                   err_nxt;
   logic [COUNT_WIDTH-1:0] count_nxt;
   logic                   rule_ok;
   logic [7:0]             b;
   logic [32:0]            count_wide;

   assign b = item.byte_value;

   always_comb begin
      case (rule_ff)
         RULE_C2, RULE_E0: rule_ok = (b >= 8'hA0);
         RULE_ED:          rule_ok = (b <= 8'h9F);
         RULE_F0:          rule_ok = (b >= 8'h90);
         RULE_F4:          rule_ok = (b <= 8'h8F);
         default:          rule_ok = 1'b1;
      endcase
   end

   always_comb begin
      count_nxt = (&count_ff) ? count_ff : count_ff + COUNT_WIDTH'(1);
      due_nxt   = due_ff;
      rule_nxt  = rule_ff;
      err_nxt   = err_ff;
      if (due_ff != 2'd0) begin
         if (b < 8'h80 || b > 8'hBF) begin
            err_nxt  = 1'b1;
            due_nxt  = 2'd0;
            rule_nxt = RULE_NONE;
         end else begin
            if (!rule_ok) begin
               err_nxt = 1'b1;
            end
            rule_nxt = RULE_NONE;
            due_nxt  = due_ff - 2'd1;
         end
      end else if (b <= 8'h7F) begin
         if (b <= 8'h1F || b == 8'h7F) begin
            err_nxt = 1'b1;
         end
      end else if (b >= 8'hC2 && b <= 8'hDF) begin
         due_nxt  = 2'd1;
         rule_nxt = (b == 8'hC2) ? RULE_C2 : RULE_NONE;
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
         due_nxt  = 2'd2;
         rule_nxt = (b == 8'hE0) ? RULE_E0 : (b == 8'hED) ? RULE_ED : RULE_NONE;
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
         due_nxt  = 2'd3;
         rule_nxt = (b == 8'hF0) ? RULE_F0 : (b == 8'hF4) ? RULE_F4 : RULE_NONE;
      end else begin
         err_nxt = 1'b1;
      end
   end

   assign count_wide = 33'(count_nxt);

   always_comb begin
      result.valid_res = !err_nxt && (due_nxt == 2'd0)
                         && (count_wide <= 33'(max_name_bytes));
      result.length    = (count_wide > 33'(16'hFFFF)) ? 16'hFFFF
                                                      : count_wide[LEN_WIDTH-1:0];
   end

   always_comb begin
      due_in   = due_ff;
      rule_in  = rule_ff;
      err_in   = err_ff;
      count_in = count_ff;
      if (step_en) begin
         if (item.is_last) begin
            due_in   = 2'd0;
            rule_in  = RULE_NONE;
            err_in   = 1'b0;
            count_in = '0;
         end else begin
            due_in   = due_nxt;
            rule_in  = rule_nxt;
            err_in   = err_nxt;
            count_in = count_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         due_ff   <= 2'd0;
         rule_ff  <= RULE_NONE;
         err_ff   <= 1'b0;
         count_ff <= '0;
      end else begin
         due_ff   <= due_in;
         rule_ff  <= rule_in;
         err_ff   <= err_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- design/utf8_control_free_validator.sv -----
// ----------------------------------------------------------------------------
// utf8_control_free_validator
// Strict, control-free UTF-8 string checker with a length limit.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one byte of a string per transaction, with is_last set
//   on the final byte. rsp_chan carries one transaction per string: valid_res
//   and the byte count (saturating at 65535). Bytes without is_last give no
//   response. The APB port (csr_*) holds max_name_bytes at offset 0; write it
//   only while no string is in flight.
//   The last byte passes the input register, then the response register,
//   before its response is offered. Throughput: one byte per cycle while no
//   last byte waits on a stalled rsp_chan, set by the single input register
//   feeding the per-byte decoder and the response register. Reset clears the
//   string state and empties both registers; max_name_bytes returns to 64.
//   While rsp_chan stalls, bytes that are not last keep flowing; a last byte
//   waits in the input register until the response register frees up.
// ----------------------------------------------------------------------------
module utf8_control_free_validator
   import u8cfv_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   u8cfv_req_if.sink                 req_chan,
   u8cfv_rsp_if.source               rsp_chan,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   logic                       in_valid_ff, in_valid_in;
   item_type                   in_item_ff,  in_item_in;
   logic                       out_valid_ff, out_valid_in;
   result_type                 out_res_ff,   out_res_in;

   logic                       out_free;
   logic                       step_en;
   logic                       req_take;
   result_type                 step_res;
   logic [MAX_BYTES_WIDTH-1:0] max_name_bytes;

   u8cfv_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .max_name_bytes (max_name_bytes)
   );

   u8cfv_decode u_decode (
      .clock          (clock),
      .reset          (reset),
      .step_en        (step_en),
      .item           (in_item_ff),
      .max_name_bytes (max_name_bytes),
      .result         (step_res)
   );

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign step_en        = in_valid_ff && (!in_item_ff.is_last || out_free);
   assign req_chan.ready = !in_valid_ff || step_en;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
      end
      if (req_take) begin
         in_item_in.byte_value = req_chan.byte_value;
         in_item_in.is_last    = req_chan.is_last;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      if (step_en && in_item_ff.is_last) begin
         out_valid_in = 1'b1;
         out_res_in   = step_res;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_item_ff <= in_item_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.valid_res = out_res_ff.valid_res;
   assign rsp_chan.length    = out_res_ff.length;

endmodule

// ----- bench/utf8_control_free_validator_tb.sv -----
// ----------------------------------------------------------------------------
// utf8_control_free_validator_tb
// Self-checking bench for the control-free UTF-8 string validator. A driver
// feeds string bytes from a queue with random gaps. A monitor stalls the
// result channel at random and checks every result against a local byte-level
// predictor. Directed strings cover the encoding corner cases. Random phases
// then run under several length limits.
// ----------------------------------------------------------------------------
module utf8_control_free_validator_tb;
   import u8cfv_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT    = 5000;
   localparam int unsigned HOLD_OFF_CYCLES   = 400;
   localparam int unsigned SETTLE_CYCLES     = 4;
   localparam int unsigned RANDOM_BYTES      = 1400;
   localparam int unsigned PHASE_BYTES       = 200;

   localparam logic [CSR_ADDR_WIDTH-1:0] NAME_LIMIT_ADDR = {REG_MAX_NAME_BYTES, 2'b00};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic       req_valid = 1'b0;
   logic [7:0] req_byte  = 8'h00;
   logic       req_last  = 1'b0;
   logic       rsp_ready = 1'b0;

   logic                      csr_psel    = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite  = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr   = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   u8cfv_req_if req_chan ();
   u8cfv_rsp_if rsp_chan ();

   assign req_chan.valid      = req_valid;
   assign req_chan.byte_value = req_byte;
   assign req_chan.is_last    = req_last;
   assign rsp_chan.ready      = rsp_ready;

   utf8_control_free_validator dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   item_type   pending_bytes[$];
   result_type expected_verdicts[$];
   logic [7:0] text_bytes[$];

   int unsigned bytes_queued    = 0;
   int unsigned failures        = 0;
   int unsigned send_gap        = 0;
   int unsigned recv_stall      = 0;
   int unsigned hold_left       = 0;
   int unsigned holds_requested = 0;
   int unsigned holds_served    = 0;
   int unsigned quiet_cycles    = 0;
   bit          send_idle       = 1'b0;
   bit          recv_idle       = 1'b0;

   // predictor state
   logic [1:0]                 continuations_left;
   rule_type                   next_byte_rule;
   logic                       string_broken;
   logic [COUNT_WIDTH-1:0]     bytes_seen;
   logic [MAX_BYTES_WIDTH-1:0] name_limit = MAX_BYTES_RESET;

   function automatic void clear_string_state();
      continuations_left = 2'd0;
      next_byte_rule     = RULE_NONE;
      string_broken      = 1'b0;
      bytes_seen         = '0;
   endfunction

   function automatic void add_text_byte(input logic [7:0] b);
      text_bytes.insert(text_bytes.size(), b);
   endfunction

   function automatic void predict_utf8_byte(input logic [7:0] b, input logic last);
      result_type verdict;
      logic       rule_ok;
      if (bytes_seen != '1)
         bytes_seen++;
      if (continuations_left != 2'd0) begin
         if (b < 8'h80 || b > 8'hbf) begin
            // broken sequence is dropped, the byte is not re-read as a lead
            string_broken      = 1'b1;
            continuations_left = 2'd0;
            next_byte_rule     = RULE_NONE;
         end else begin
            case (next_byte_rule)
               RULE_C2, RULE_E0: rule_ok = (b >= 8'ha0);
               RULE_ED:          rule_ok = (b <= 8'h9f);
               RULE_F0:          rule_ok = (b >= 8'h90);
               RULE_F4:          rule_ok = (b <= 8'h8f);
               default:          rule_ok = 1'b1;
            endcase
            if (!rule_ok)
               string_broken = 1'b1;
            next_byte_rule = RULE_NONE;
            continuations_left--;
         end
      end else if (b <= 8'h7f) begin
         if (b <= 8'h1f || b == 8'h7f)
            string_broken = 1'b1;
      end else if (b >= 8'hc2 && b <= 8'hdf) begin
         continuations_left = 2'd1;
         next_byte_rule     = (b == 8'hc2) ? RULE_C2 : RULE_NONE;
      end else if (b >= 8'he0 && b <= 8'hef) begin
         continuations_left = 2'd2;
         next_byte_rule     = (b == 8'he0) ? RULE_E0 : (b == 8'hed) ? RULE_ED : RULE_NONE;
      end else if (b >= 8'hf0 && b <= 8'hf4) begin
         continuations_left = 2'd3;
         next_byte_rule     = (b == 8'hf0) ? RULE_F0 : (b == 8'hf4) ? RULE_F4 : RULE_NONE;
      end else
         string_broken = 1'b1;
      if (last) begin
         verdict.valid_res = !string_broken && continuations_left == 2'd0 &&
                             bytes_seen <= name_limit;
         verdict.length    = (bytes_seen > 16'hffff) ? '1 : LEN_WIDTH'(bytes_seen);
         expected_verdicts.insert(expected_verdicts.size(), verdict);
         clear_string_state();
      end
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 65)
         return 0;
      if (roll < 95)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void append_code_point(input int unsigned cp);
      if (cp < 32'h80)
         add_text_byte(8'(cp));
      else if (cp < 32'h800) begin
         add_text_byte(8'hc0 | 8'(cp >> 6));
         add_text_byte(8'h80 | 8'(cp & 32'h3f));
      end else if (cp < 32'h10000) begin
         add_text_byte(8'he0 | 8'(cp >> 12));
         add_text_byte(8'h80 | 8'((cp >> 6) & 32'h3f));
         add_text_byte(8'h80 | 8'(cp & 32'h3f));
      end else begin
         add_text_byte(8'hf0 | 8'(cp >> 18));
         add_text_byte(8'h80 | 8'((cp >> 12) & 32'h3f));
         add_text_byte(8'h80 | 8'((cp >> 6) & 32'h3f));
         add_text_byte(8'h80 | 8'(cp & 32'h3f));
      end
   endfunction

   function automatic int unsigned random_code_point();
      int unsigned cp;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: cp = $urandom_range(32'h20, 32'h7e);
         4:          cp = $urandom_range(32'ha0, 32'h7ff);
         5, 6: begin
            cp = $urandom_range(32'h800, 32'hffff);
            if (cp >= 32'hd800 && cp <= 32'hdfff)
               cp += 32'h800;
         end
         7:          cp = $urandom_range(32'h10000, 32'h10ffff);
         default: begin
            case ($urandom_range(0, 15))
               0:       cp = 32'h20;
               1:       cp = 32'h7e;
               2:       cp = 32'ha0;
               3:       cp = 32'ha1;
               4:       cp = 32'h7ff;
               5:       cp = 32'h800;
               6:       cp = 32'hfff;
               7:       cp = 32'h1000;
               8:       cp = 32'hcfff;
               9:       cp = 32'hd7ff;
               10:      cp = 32'he000;
               11:      cp = 32'hfffd;
               12:      cp = 32'hffff;
               13:      cp = 32'h10000;
               14:      cp = 32'h100000;
               default: cp = 32'h10ffff;
            endcase
         end
      endcase
      return cp;
   endfunction

   task automatic queue_text();
      item_type entry;
      foreach (text_bytes[i]) begin
         entry.byte_value = text_bytes[i];
         entry.is_last    = (i == text_bytes.size() - 1);
         pending_bytes.insert(pending_bytes.size(), entry);
      end
      bytes_queued += text_bytes.size();
      text_bytes.delete();
   endtask

   task automatic queue_packed(input logic [31:0] word, input int unsigned count);
      for (int i = int'(count) - 1; i >= 0; i--)
         add_text_byte(word[8*i +: 8]);
      queue_text();
   endtask

   task automatic queue_random_string();
      int unsigned points;
      int unsigned pos;
      points = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (int unsigned i = 0; i < points; i++)
         append_code_point(random_code_point());
      case ($urandom_range(0, 9))
         6: begin
            // multi-byte sequence cut short at the end of the string
            append_code_point($urandom_range(32'h80, 32'h10ffff));
            void'(text_bytes.pop_back());
         end
         7: begin
            pos             = $urandom_range(0, text_bytes.size() - 1);
            text_bytes[pos] = 8'($urandom);
         end
         8: begin
            case ($urandom_range(0, 7))
               0: append_code_point($urandom_range(0, 32'h1f));
               1: append_code_point(32'h7f);
               2: append_code_point($urandom_range(32'h80, 32'h9f));
               3: append_code_point($urandom_range(32'hd800, 32'hdfff));
               4: append_code_point($urandom_range(32'h110000, 32'h1fffff));
               5: begin
                  add_text_byte(8'hc0 | 8'($urandom_range(0, 1)));
                  add_text_byte(8'h80 | 8'($urandom_range(0, 63)));
               end
               6: begin
                  add_text_byte(8'he0);
                  add_text_byte(8'($urandom_range(8'h80, 8'h9f)));
                  add_text_byte(8'h80 | 8'($urandom_range(0, 63)));
               end
               default: begin
                  add_text_byte(8'hf0);
                  add_text_byte(8'($urandom_range(8'h80, 8'h8f)));
                  add_text_byte(8'h80 | 8'($urandom_range(0, 63)));
                  add_text_byte(8'h80 | 8'($urandom_range(0, 63)));
               end
            endcase
            repeat ($urandom_range(0, 2))
               append_code_point(random_code_point());
         end
         9: begin
            text_bytes.delete();
            repeat ($urandom_range(1, 6))
               add_text_byte(8'($urandom));
         end
         default: ;
      endcase
      queue_text();
   endtask

   task automatic wait_quiet();
      do
         @(negedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_verdicts.size() != 0);
      repeat (SETTLE_CYCLES)
         @(negedge clock);
   endtask

   // reads back the current limit, then writes the new one
   task automatic program_name_limit(input logic [MAX_BYTES_WIDTH-1:0] limit);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= NAME_LIMIT_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      if (csr_prdata !== CSR_DATA_WIDTH'(name_limit)) begin
         $display("%0t: max_name_bytes read mismatch: expected %0d, got %0d",
                  $time, name_limit, csr_prdata);
         failures++;
      end
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_pwdata  <= CSR_DATA_WIDTH'(limit);
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      name_limit = limit;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   always @(posedge clock) begin : byte_driver
      item_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
         clear_string_state();
      end else begin
         if (req_valid && req_chan.ready)
            predict_utf8_byte(req_byte, req_last);
         if (!req_valid || req_chan.ready) begin
            if (send_gap != 0) begin
               req_valid <= 1'b0;
               send_gap  <= send_gap - 1;
            end else if (pending_bytes.size() != 0) begin
               next_item = pending_bytes.pop_front();
               req_valid <= 1'b1;
               req_byte  <= next_item.byte_value;
               req_last  <= next_item.is_last;
               send_gap  <= send_idle ? pick_gap() : 0;
            end else
               req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : verdict_monitor
      result_type verdict;
      if (reset) begin
         rsp_ready    <= 1'b0;
         recv_stall   <= 0;
         hold_left    <= 0;
         holds_served <= 0;
      end else begin
         if (rsp_chan.valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               $display("%0t: result with none expected: valid_res %0b, length %0d",
                        $time, rsp_chan.valid_res, rsp_chan.length);
               failures++;
            end else begin
               verdict = expected_verdicts.pop_front();
               if (rsp_chan.valid_res !== verdict.valid_res) begin
                  $display("%0t: valid_res mismatch: expected %0b, got %0b",
                           $time, verdict.valid_res, rsp_chan.valid_res);
                  failures++;
               end
               if (rsp_chan.length !== verdict.length) begin
                  $display("%0t: length mismatch: expected %0d, got %0d",
                           $time, verdict.length, rsp_chan.length);
                  failures++;
               end
            end
         end
         if (holds_served != holds_requested) begin
            holds_served <= holds_requested;
            hold_left    <= HOLD_OFF_CYCLES;
            rsp_ready    <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (recv_stall != 0) begin
            recv_stall <= recv_stall - 1;
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready  <= 1'b1;
            recv_stall <= recv_idle ? pick_gap() : 0;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_chan.ready) || (rsp_chan.valid && rsp_ready) ||
          (csr_psel && csr_penable))
         quiet_cycles <= 0;
      else if (quiet_cycles < WATCHDOG_LIMIT)
         quiet_cycles <= quiet_cycles + 1;
      else begin
         $display("utf8_control_free_validator regression: fail");
         $finish;
      end
   end

   initial begin : stimulus
      logic [MAX_BYTES_WIDTH-1:0] limit;
      int unsigned                phase;
      int unsigned                random_start;
      int unsigned                phase_start;

      repeat (5)
         @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle = 1'b1;
      recv_idle = 1'b1;
      queue_packed(32'h41, 1);
      queue_packed(32'h00, 1);
      queue_packed(32'h7f, 1);
      queue_packed(32'hc1, 1);
      queue_packed(32'hff, 1);
      queue_packed(32'h80, 1);
      queue_packed(32'hc29f, 2);
      queue_packed(32'he09fbf, 3);
      queue_packed(32'heda080, 3);
      queue_packed(32'hf08f8080, 4);
      queue_packed(32'hf4908080, 4);
      queue_packed(32'he282, 2);
      queue_packed(32'hc341, 2);
      wait_quiet();

      program_name_limit(16'd1);
      queue_packed(32'h41, 1);
      queue_packed(32'h4142, 2);
      wait_quiet();

      program_name_limit(16'd0);
      queue_packed(32'h41, 1);
      wait_quiet();

      phase        = 0;
      random_start = bytes_queued;
      while (bytes_queued - random_start < RANDOM_BYTES) begin
         case (phase % 6)
            0:       limit = 16'hffff;
            1:       limit = 16'($urandom_range(2, 40));
            2:       limit = MAX_BYTES_RESET;
            3:       limit = 16'($urandom_range(41, 300));
            4:       limit = 16'd1;
            default: limit = 16'($urandom_range(2, 65534));
         endcase
         program_name_limit(limit);
         send_idle = ($urandom_range(0, 3) != 0);
         recv_idle = ($urandom_range(0, 3) != 0);
         if (phase % 3 == 1)
            holds_requested++;
         phase_start = bytes_queued;
         while (bytes_queued - phase_start < PHASE_BYTES)
            queue_random_string();
         wait_quiet();
         phase++;
      end

      program_name_limit(MAX_BYTES_RESET);
      queue_packed(32'h41, 1);
      wait_quiet();

      if (failures == 0)
         $display("utf8_control_free_validator regression: pass");
      else
         $display("utf8_control_free_validator regression: fail");
      $finish;
   end

endmodule
